[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, held off while reset is high
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked property, also during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/dfhs_pkg.sv]
`default_nettype none
package dfhs_pkg;

   localparam int KEY_WIDTH         = 31;
   localparam int QUEUE_DEPTH_DEF   = 512;
   localparam int TABLE_DEPTH_DEF   = 1024;
   localparam int LINK_DEPTH_DEF    = 4;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_NEXT  = 2'd1,
      CMD_CHECK = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_ADDED   = 3'd0,
      ST_DUP     = 3'd1,
      ST_DEQ     = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_PRESENT = 3'd4,
      ST_ABSENT  = 3'd5,
      ST_FULL    = 3'd6
   } status_type;

   typedef logic [1:0] tag_type;
   localparam tag_type TAG_EMPTY = 2'd0;
   localparam tag_type TAG_LIVE  = 2'd1;
   localparam tag_type TAG_TOMB  = 2'd2;

   typedef struct packed {
      cmd_type              command;
      logic [KEY_WIDTH-1:0] key;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [KEY_WIDTH-1:0] value;
   } rsp_type;

endpackage
`default_nettype wire

[rtl/dfhs_ram.sv]
`default_nettype none
module dfhs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[rtl/dfhs_queue.sv]
`default_nettype none
module dfhs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic      [WIDTH-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

[rtl/dfhs_front.sv]
`default_nettype none
module dfhs_front #(
   parameter int TABLE_DEPTH = dfhs_pkg::TABLE_DEPTH_DEF,
   parameter int WORK_W      = 2 + dfhs_pkg::KEY_WIDTH + $clog2(TABLE_DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire dfhs_pkg::req_type req_data,
   output logic                   full,
   input  wire logic              clearing,
   output logic                   work_push,
   output logic      [WORK_W-1:0] work_data,
   input  wire logic              work_full
);
   localparam int TW = $clog2(TABLE_DEPTH);
   localparam int KW = dfhs_pkg::KEY_WIDTH;

   typedef enum logic {F_IDLE, F_SEND} fstate_type;

   fstate_type        state_ff;
   dfhs_pkg::cmd_type cmd_ff;
   logic [KW-1:0]     key_ff;

   assign full = (state_ff != F_IDLE) || clearing;

   assign work_push = (state_ff == F_SEND);
   // table depth is a power of two: key mod TABLE_DEPTH is the low key bits
   assign work_data = {cmd_ff, key_ff, key_ff[TW-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (push && !full) begin
                  cmd_ff   <= req_data.command;
                  key_ff   <= req_data.key;
                  state_ff <= F_SEND;
               end
            end
            F_SEND: begin
               if (!work_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

[rtl/dfhs_engine.sv]
`default_nettype none
`include "assert_macros.svh"
module dfhs_engine #(
   parameter int QUEUE_DEPTH = dfhs_pkg::QUEUE_DEPTH_DEF,
   parameter int TABLE_DEPTH = dfhs_pkg::TABLE_DEPTH_DEF,
   parameter int WORK_W      = 2 + dfhs_pkg::KEY_WIDTH + $clog2(TABLE_DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   output logic                   clearing,
   input  wire logic              work_empty,
   input  wire logic [WORK_W-1:0] work_data,
   output logic                   work_pop,
   input  wire logic              res_full,
   output logic                   res_push,
   output dfhs_pkg::rsp_type      res_data
);
   localparam int TW = $clog2(TABLE_DEPTH);
   localparam int KW = dfhs_pkg::KEY_WIDTH;
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DEQ_WAIT, S_PROBE_RD, S_PROBE_CHK} estate_type;

   estate_type        state_ff;
   dfhs_pkg::cmd_type op_ff, w_cmd;
   logic [KW-1:0]     key_ff, w_key, r_key;
   logic [TW-1:0]     hash_ff, addr_ff, steps_ff, tomb_addr_ff, clr_addr_ff, w_hash;
   logic              tomb_seen_ff;
   logic [QW-1:0]     head_ff, tail_ff;
   logic [CW-1:0]     count_ff;

   logic                tbl_we;
   logic [TW-1:0]       tbl_waddr;
   logic [KW+1:0]       tbl_wdata, tbl_rdata;
   logic                q_we;
   logic [KW+TW-1:0]    q_wdata, q_rdata;
   dfhs_pkg::tag_type   r_tag;
   logic                hit_empty, hit_match, last, done, tomb_now, tomb_any, can_ins, q_full;
   logic                do_insert;
   logic [TW-1:0]       tomb_slot, ins_slot, next_addr;

   assign {w_cmd, w_key, w_hash} = work_data;
   assign clearing = (state_ff == S_CLEAR);
   assign work_pop = (state_ff == S_IDLE) && !work_empty && !res_full;
   assign q_full   = (count_ff == CW'(QUEUE_DEPTH));

   assign r_tag     = tbl_rdata[KW+1:KW];
   assign r_key     = tbl_rdata[KW-1:0];
   assign hit_empty = (r_tag == dfhs_pkg::TAG_EMPTY);
   assign hit_match = (r_tag == dfhs_pkg::TAG_LIVE) && (r_key == key_ff);
   assign last      = (steps_ff == TW'(TABLE_DEPTH - 1));
   assign done      = hit_empty || hit_match || last;
   assign tomb_now  = (r_tag == dfhs_pkg::TAG_TOMB) && !tomb_seen_ff;
   assign tomb_any  = tomb_seen_ff || tomb_now;
   assign tomb_slot = tomb_seen_ff ? tomb_addr_ff : addr_ff;
   assign ins_slot  = tomb_any ? tomb_slot : addr_ff;
   assign can_ins   = tomb_any || hit_empty;
   assign next_addr = (addr_ff == TW'(TABLE_DEPTH - 1)) ? '0 : addr_ff + 1'b1;
   assign do_insert = (state_ff == S_PROBE_CHK) && done && (op_ff == dfhs_pkg::CMD_ADD)
                      && !hit_match && !q_full && can_ins;

   always_comb begin
      tbl_we    = 1'b0;
      tbl_waddr = addr_ff;
      tbl_wdata = {dfhs_pkg::TAG_TOMB, r_key};
      if (state_ff == S_CLEAR) begin
         tbl_we    = 1'b1;
         tbl_waddr = clr_addr_ff;
         tbl_wdata = '0;
      end else if (do_insert) begin
         tbl_we    = 1'b1;
         tbl_waddr = ins_slot;
         tbl_wdata = {dfhs_pkg::TAG_LIVE, key_ff};
      end else if (state_ff == S_PROBE_CHK && done && op_ff == dfhs_pkg::CMD_NEXT && hit_match) begin
         tbl_we = 1'b1;
      end
   end

   assign q_we    = do_insert;
   assign q_wdata = {key_ff, hash_ff};

   always_comb begin
      res_push       = 1'b0;
      res_data.value = '0;
      res_data.status = dfhs_pkg::ST_ABSENT;
      if (work_pop) begin
         case (w_cmd)
            dfhs_pkg::CMD_NEXT: begin
               res_push        = (count_ff == '0);
               res_data.status = dfhs_pkg::ST_EMPTY;
            end
            dfhs_pkg::CMD_NONE: res_push = 1'b1;
            default: res_push = 1'b0;
         endcase
      end else if (state_ff == S_PROBE_CHK && done) begin
         res_push = 1'b1;
         case (op_ff)
            dfhs_pkg::CMD_ADD: begin
               if (hit_match) begin
                  res_data.status = dfhs_pkg::ST_DUP;
               end else if (q_full || !can_ins) begin
                  res_data.status = dfhs_pkg::ST_FULL;
               end else begin
                  res_data.status = dfhs_pkg::ST_ADDED;
               end
            end
            dfhs_pkg::CMD_NEXT: begin
               res_data.status = dfhs_pkg::ST_DEQ;
               res_data.value  = key_ff;
            end
            default: begin
               res_data.status = hit_match ? dfhs_pkg::ST_PRESENT : dfhs_pkg::ST_ABSENT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         tomb_seen_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == TW'(TABLE_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (work_pop) begin
                  op_ff        <= w_cmd;
                  key_ff       <= w_key;
                  hash_ff      <= w_hash;
                  addr_ff      <= w_hash;
                  steps_ff     <= '0;
                  tomb_seen_ff <= 1'b0;
                  case (w_cmd)
                     dfhs_pkg::CMD_ADD, dfhs_pkg::CMD_CHECK: state_ff <= S_PROBE_RD;
                     dfhs_pkg::CMD_NEXT: begin
                        if (count_ff != '0) begin
                           state_ff <= S_DEQ_WAIT;
                        end
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_DEQ_WAIT: begin
               // stored hash comes back with the key, no second modulo
               key_ff   <= q_rdata[KW+TW-1:TW];
               hash_ff  <= q_rdata[TW-1:0];
               addr_ff  <= q_rdata[TW-1:0];
               head_ff  <= (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               count_ff <= count_ff - 1'b1;
               state_ff <= S_PROBE_RD;
            end
            S_PROBE_RD: state_ff <= S_PROBE_CHK;
            S_PROBE_CHK: begin
               if (done) begin
                  state_ff <= S_IDLE;
                  if (do_insert) begin
                     tail_ff  <= (tail_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                     count_ff <= count_ff + 1'b1;
                  end
               end else begin
                  if (tomb_now) begin
                     tomb_seen_ff <= 1'b1;
                     tomb_addr_ff <= addr_ff;
                  end
                  addr_ff  <= next_addr;
                  steps_ff <= steps_ff + 1'b1;
                  state_ff <= S_PROBE_RD;
               end
            end
            default: state_ff <= S_CLEAR;
         endcase
      end
   end

   dfhs_ram #(.WIDTH(KW + 2), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (addr_ff),
      .rd_data (tbl_rdata)
   );

   dfhs_ram #(.WIDTH(KW + TW), .DEPTH(QUEUE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (tail_ff),
      .wr_data (q_wdata),
      .rd_addr (head_ff),
      .rd_data (q_rdata)
   );

   `ASSERT_RST(a_count_bound, clock, reset, count_ff <= CW'(QUEUE_DEPTH), "queue count overflow")
   `ASSERT_RST(a_ring_ptrs, clock, reset, (head_ff == tail_ff) == (count_ff == '0 || q_full), "ring pointers disagree with count")
   `ASSERT_RST(a_no_pop_clear, clock, reset, clearing |-> !work_pop && !res_push, "transfer during clearing pass")
   `ASSERT_RST(a_insert_room, clock, reset, do_insert |=> count_ff == $past(count_ff) + 1'b1, "insert lost")

endmodule
`default_nettype wire

[rtl/dedup_fifo_with_hash_set.sv]
//  channel  | ports                    | transfer when
//  ---------+--------------------------+-------------------
//  request  | push, full, req_data     | push && !full
//  response | pop, empty, rsp_data     | pop && !empty
//
// After reset the slot table is swept to empty with full held high. The front holds one
// item until the link queue takes it; the hash is the low key bits (TABLE_DEPTH a power
// of 2). The back pops one item at a time from the link queue, then reads and checks each
// probed slot for add, check; next reads the key store first. An empty next and code 3 are
// answered at the pop. Results wait in a small output queue; a full one stalls the back.
`default_nettype none
module dedup_fifo_with_hash_set #(
   parameter int QUEUE_DEPTH = dfhs_pkg::QUEUE_DEPTH_DEF,
   parameter int TABLE_DEPTH = dfhs_pkg::TABLE_DEPTH_DEF,
   parameter int LINK_DEPTH  = dfhs_pkg::LINK_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire dfhs_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output dfhs_pkg::rsp_type      rsp_data
);
   localparam int WORK_W = 2 + dfhs_pkg::KEY_WIDTH + $clog2(TABLE_DEPTH);

   logic              clearing, work_push, work_full, work_empty, work_pop;
   logic              res_push, res_full;
   logic [WORK_W-1:0] work_in, work_out;
   dfhs_pkg::rsp_type res_data;

   dfhs_front #(.TABLE_DEPTH(TABLE_DEPTH), .WORK_W(WORK_W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .clearing  (clearing),
      .work_push (work_push),
      .work_data (work_in),
      .work_full (work_full)
   );

   dfhs_queue #(.WIDTH(WORK_W), .DEPTH(LINK_DEPTH)) u_link (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (work_in),
      .full      (work_full),
      .pop       (work_pop),
      .empty     (work_empty),
      .pop_data  (work_out)
   );

   dfhs_engine #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TABLE_DEPTH (TABLE_DEPTH),
      .WORK_W      (WORK_W)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .clearing   (clearing),
      .work_empty (work_empty),
      .work_data  (work_out),
      .work_pop   (work_pop),
      .res_full   (res_full),
      .res_push   (res_push),
      .res_data   (res_data)
   );

   dfhs_queue #(.WIDTH($bits(dfhs_pkg::rsp_type)), .DEPTH(LINK_DEPTH)) u_resp (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (rsp_data)
   );
endmodule
`default_nettype wire

[bench/dedup_fifo_with_hash_set_checker.sv]
`default_nettype none
module dedup_fifo_with_hash_set_checker #(
   parameter int QUEUE_DEPTH = dfhs_pkg::QUEUE_DEPTH_DEF,
   parameter int TABLE_DEPTH = dfhs_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic              full,
   input  wire dfhs_pkg::req_type req_data,
   input  wire logic              empty,
   input  wire logic              pop,
   input  wire dfhs_pkg::rsp_type rsp_data,
   output int                     mismatch_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KW = dfhs_pkg::KEY_WIDTH;

   logic [KW-1:0]     queued_keys[QUEUE_DEPTH];
   int                q_head, q_tail, q_fill;
   logic [KW-1:0]     set_key[TABLE_DEPTH];
   dfhs_pkg::tag_type set_tag[TABLE_DEPTH];
   dfhs_pkg::rsp_type expected_rsps[$];

   task automatic report_mismatch(input string what);
      $display("%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic void find_slot(input logic [KW-1:0] k, output int hit,
                                     output int tomb, output int free);
      int s;
      s = k % TABLE_DEPTH;
      hit = -1; tomb = -1; free = -1;
      for (int n = 0; n < TABLE_DEPTH; n++) begin
         if (set_tag[s] == dfhs_pkg::TAG_EMPTY) begin
            free = s;
            return;
         end
         if (set_tag[s] == dfhs_pkg::TAG_LIVE && set_key[s] == k) begin
            hit = s;
            return;
         end
         if (set_tag[s] == dfhs_pkg::TAG_TOMB && tomb < 0) tomb = s;
         s = (s + 1) % TABLE_DEPTH;
      end
   endfunction

   function automatic void apply_command(input dfhs_pkg::req_type rq);
      dfhs_pkg::rsp_type r;
      int                hit, tomb, free, s;
      logic [KW-1:0]     v;
      r.status = dfhs_pkg::ST_ABSENT;
      r.value  = '0;
      case (rq.command)
         dfhs_pkg::CMD_ADD: begin
            find_slot(rq.key, hit, tomb, free);
            if (hit >= 0) r.status = dfhs_pkg::ST_DUP;
            else if (q_fill >= QUEUE_DEPTH || (tomb < 0 && free < 0))
               r.status = dfhs_pkg::ST_FULL;
            else begin
               s = (tomb >= 0) ? tomb : free;
               set_key[s] = rq.key;
               set_tag[s] = dfhs_pkg::TAG_LIVE;
               queued_keys[q_tail] = rq.key;
               q_tail = (q_tail + 1) % QUEUE_DEPTH;
               q_fill++;
               r.status = dfhs_pkg::ST_ADDED;
            end
         end
         dfhs_pkg::CMD_NEXT: begin
            if (q_fill == 0) r.status = dfhs_pkg::ST_EMPTY;
            else begin
               v = queued_keys[q_head];
               q_head = (q_head + 1) % QUEUE_DEPTH;
               q_fill--;
               find_slot(v, hit, tomb, free);
               if (hit >= 0) set_tag[hit] = dfhs_pkg::TAG_TOMB;
               r.status = dfhs_pkg::ST_DEQ;
               r.value  = v;
            end
         end
         dfhs_pkg::CMD_CHECK: begin
            find_slot(rq.key, hit, tomb, free);
            r.status = (hit >= 0) ? dfhs_pkg::ST_PRESENT : dfhs_pkg::ST_ABSENT;
         end
         default: ;
      endcase
      expected_rsps.push_back(r);
   endfunction

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         q_head = 0; q_tail = 0; q_fill = 0;
         foreach (set_tag[i]) set_tag[i] = dfhs_pkg::TAG_EMPTY;
         expected_rsps.delete();
      end else begin
         // response side first: a result never comes out in the cycle its command goes in
         if (pop && !empty) begin
            if (expected_rsps.size() == 0)
               report_mismatch($sformatf("unexpected result status %0d", rsp_data.status));
            else begin
               dfhs_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_data.status !== e.status)
                  report_mismatch($sformatf("status %0d, want %0d", rsp_data.status,
                                            e.status));
               if (rsp_data.value !== e.value)
                  report_mismatch($sformatf("value %0h, want %0h", rsp_data.value,
                                            e.value));
            end
         end
         if (push && !full) apply_command(req_data);
      end
      pending_count = expected_rsps.size();
   end
endmodule
`default_nettype wire

[bench/dedup_fifo_with_hash_set_tb.sv]
`default_nettype none
module dedup_fifo_with_hash_set_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KW          = dfhs_pkg::KEY_WIDTH;
   localparam int TD          = dfhs_pkg::TABLE_DEPTH_DEF;
   localparam int QD          = dfhs_pkg::QUEUE_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 30_000_000;
   localparam int LONG_HOLD   = 300;

   logic              clock, reset, push, pop, full, empty;
   dfhs_pkg::req_type req_data;
   dfhs_pkg::rsp_type rsp_data;
   int                mismatch_count, pending_count;
   int                cycle_count = 0;
   bit                hold_off;
   bit                fill_phase = 1'b0;
   logic [KW-1:0]     recent_keys[$];

   dedup_fifo_with_hash_set dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   dedup_fifo_with_hash_set_checker checker_i (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // push held until the transfer; caller leaves push high between burst items
   task automatic send(input dfhs_pkg::cmd_type c, input logic [KW-1:0] k);
      req_data.command <= c;
      req_data.key     <= k;
      push             <= 1'b1;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   function automatic logic [KW-1:0] pick_key();
      case ($urandom_range(0, 9))
         0, 1, 2: return (recent_keys.size() > 0) ?
                         recent_keys[$urandom_range(0, recent_keys.size() - 1)] : '0;
         3:       return KW'($urandom_range(0, 3)) * KW'(TD)
                         + KW'($urandom_range(0, 2));
         4:       return {KW{1'b1}} - KW'($urandom_range(0, 3));
         default: return KW'($urandom());
      endcase
   endfunction

   task automatic random_item();
      logic [KW-1:0]     k;
      dfhs_pkg::cmd_type c;
      int                r;
      r = $urandom_range(0, 99);
      k = pick_key();
      if (r < 45) c = dfhs_pkg::CMD_ADD;
      else if (r < 75) c = dfhs_pkg::CMD_NEXT;
      else if (r < 97) c = dfhs_pkg::CMD_CHECK;
      else c = dfhs_pkg::CMD_NONE;
      if (c == dfhs_pkg::CMD_ADD) begin
         recent_keys.push_back(k);
         if (recent_keys.size() > 40) void'(recent_keys.pop_front());
      end
      send(c, k);
   endtask

   // receiver: own stall pattern, plus the long hold-off
   initial begin
      int mode;
      pop = 1'b0;
      @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(4, 40)) begin
            @(negedge clock);
            if (hold_off) pop <= 1'b0;
            else case (mode)
               0: pop <= 1'b1;
               1: pop <= ($urandom_range(0, 3) != 0);
               2: pop <= ($urandom_range(0, 3) == 0);
               default: pop <= $urandom_range(0, 1);
            endcase
         end
      end
   end

   // long hold-off, counted here while the sender keeps offering items
   initial begin
      hold_off = 1'b0;
      wait (fill_phase);
      hold_off = 1'b1;
      repeat (LONG_HOLD) @(negedge clock);
      hold_off = 1'b0;
   end

   initial begin
      logic [KW-1:0] max_key;
      max_key = {KW{1'b1}};
      push = 1'b0; req_data = '0; reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty dequeue, key zero, extremes, collisions, tombstone reuse
      send(dfhs_pkg::CMD_NEXT, '0);
      send(dfhs_pkg::CMD_CHECK, '0);
      send(dfhs_pkg::CMD_ADD, '0);
      send(dfhs_pkg::CMD_ADD, '0);
      send(dfhs_pkg::CMD_CHECK, '0);
      send(dfhs_pkg::CMD_ADD, max_key);
      send(dfhs_pkg::CMD_ADD, KW'(TD));
      send(dfhs_pkg::CMD_ADD, KW'(2 * TD));
      send(dfhs_pkg::CMD_CHECK, KW'(2 * TD));
      send(dfhs_pkg::CMD_CHECK, KW'(3 * TD));
      send(dfhs_pkg::CMD_NEXT, '0);
      send(dfhs_pkg::CMD_CHECK, '0);
      send(dfhs_pkg::CMD_CHECK, KW'(2 * TD));
      send(dfhs_pkg::CMD_ADD, KW'(3 * TD));
      send(dfhs_pkg::CMD_ADD, '0);
      send(dfhs_pkg::CMD_NONE, max_key);
      send(dfhs_pkg::CMD_ADD, 31'h5555_5555);
      send(dfhs_pkg::CMD_ADD, 31'h2aaa_aaaa);
      repeat (8) send(dfhs_pkg::CMD_NEXT, max_key);

      // fill the queue past its depth, with the receiver holding off as the fill begins
      fill_phase = 1'b1;
      for (int i = 0; i < QD + 4; i++)
         send(dfhs_pkg::CMD_ADD, KW'(i * 7 + 1));
      for (int i = 0; i < QD + 2; i++) send(dfhs_pkg::CMD_NEXT, '0);

      for (int n = 0; n < 550; ) begin
         int burst;
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst; b++, n++) random_item();
         if ($urandom_range(0, 3) != 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
      push <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/dfhs_pkg.sv
rtl/dfhs_ram.sv
rtl/dfhs_queue.sv
rtl/dfhs_front.sv
rtl/dfhs_engine.sv
rtl/dedup_fifo_with_hash_set.sv
bench/dedup_fifo_with_hash_set_checker.sv
bench/dedup_fifo_with_hash_set_tb.sv
